@@ sv/cas_pkg.sv @@
// ----------------------------------------------------------------------------
// cas_pkg: shared definitions for the compacting array store
// Operation and status codes, the per-cell command and the control bundle
// that the sequencer broadcasts along the cell chain.
// ----------------------------------------------------------------------------
package cas_pkg;

   localparam int DATA_W        = 32;
   localparam int DEPTH_DEFAULT = 16;

   // Request operation codes.
   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_DUMP   = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // What every cell does in the current cycle.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_APPEND,
      CELL_CLOSE,
      CELL_ROTATE
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type              cmd;
      logic signed [DATA_W-1:0] value;
   } cell_ctl_type;

endpackage

@@ sv/cas_cell.sv @@
// ----------------------------------------------------------------------------
// cas_cell: one storage cell of the compacting array store
// Holds a single entry and decides from its own position whether to keep
// it, take a new value, the entry handed over by its neighbor or the head entry.
// ----------------------------------------------------------------------------
module cas_cell
   import cas_pkg::*;
#(
   parameter int IDX   = 0,
   parameter int CNT_W = 5,
   parameter int POS_W = 4
) (
   input  logic                     clock,
   input  cell_ctl_type             ctl,
   input  logic [CNT_W-1:0]         fill_count,
   input  logic [POS_W-1:0]         position,
   input  logic signed [DATA_W-1:0] next_entry,
   input  logic signed [DATA_W-1:0] head_entry,
   output logic signed [DATA_W-1:0] entry
);

   localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
   localparam logic [CNT_W-1:0] NXT_IDX = CNT_W'(IDX + 1);

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      case (ctl.cmd)
         CELL_APPEND: begin
            if (fill_count == MY_IDX) begin
               entry_in = ctl.value;
            end
         end
         CELL_CLOSE: begin
            // Cells from the removed slot up to the one below the last occupied cell take their upper neighbor.
            if ((MY_IDX >= CNT_W'(position)) && (NXT_IDX < fill_count)) begin
               entry_in = next_entry;
            end
         end
         CELL_ROTATE: begin
            // The occupied part of the chain turns by one; the head wraps
            // around into the last occupied cell.
            if (NXT_IDX < fill_count) begin
               entry_in = next_entry;
            end else if (NXT_IDX == fill_count) begin
               entry_in = head_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

@@ sv/compacting_array_store_core.sv @@
// ----------------------------------------------------------------------------
// compacting_array_store_core: bounded ordered store with append and delete
// Push appends at the end, remove deletes at a position and closes the gap,
// dump streams every stored entry in order. Storage is a chain of cells.
// ----------------------------------------------------------------------------
// Timing: a push, remove or other single-result request shows its result
// beat in the cycle after acceptance; a dump first enters its dump state and
// then gives one beat per cycle while the result register is free.
// Throughput: one push or remove per cycle while the result register is free;
// a dump takes no new request until its last beat, one chain rotation per beat.
// Reset clears the fill count, the sequencer and the result valid, not the entries.
module compacting_array_store_core
   import cas_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int CNT_W = $clog2(DEPTH + 1),
   parameter int POS_W = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_operation,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic [POS_W-1:0]         req_position,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_element,
   output logic                     rsp_element_valid,
   output logic                     rsp_last,
   output logic [1:0]               rsp_status,
   output logic [CNT_W-1:0]         rsp_count
);

   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

   // Sequencer state and the registered result beat.
   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         fill_count_ff, fill_count_in;
   logic [POS_W-1:0]         dump_idx_ff, dump_idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_element_ff, rsp_element_in;
   logic                     rsp_element_valid_ff, rsp_element_valid_in;
   logic                     rsp_last_ff, rsp_last_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]         rsp_count_ff, rsp_count_in;

   logic                     out_free;
   logic                     req_accept;
   logic                     dump_last;
   cell_ctl_type             cell_ctl;
   logic signed [DATA_W-1:0] cell_entry [DEPTH];

   // The result register is free when it is empty or its beat leaves now.
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && out_free;
   assign req_accept = req_valid && req_ready;
   assign dump_last  = ((CNT_W'(dump_idx_ff) + CNT_W'(1)) == fill_count_ff);

   always_comb begin
      state_in             = state_ff;
      fill_count_in        = fill_count_ff;
      dump_idx_in          = dump_idx_ff;
      rsp_valid_in         = out_free ? 1'b0 : rsp_valid_ff;
      rsp_element_in       = rsp_element_ff;
      rsp_element_valid_in = rsp_element_valid_ff;
      rsp_last_in          = rsp_last_ff;
      rsp_status_in        = rsp_status_ff;
      rsp_count_in         = rsp_count_ff;
      cell_ctl.cmd         = CELL_HOLD;
      cell_ctl.value       = req_value;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               // Every request except a non-empty dump answers with a single
               // beat that carries no element.
               rsp_valid_in         = 1'b1;
               rsp_element_in       = '0;
               rsp_element_valid_in = 1'b0;
               rsp_last_in          = 1'b1;
               rsp_status_in        = STATUS_OK;
               rsp_count_in         = fill_count_ff;
               case (req_operation)
                  OP_PUSH: begin
                     if (fill_count_ff == FULL_CNT) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        cell_ctl.cmd  = CELL_APPEND;
                        fill_count_in = fill_count_ff + CNT_W'(1);
                        rsp_count_in  = fill_count_ff + CNT_W'(1);
                     end
                  end
                  OP_REMOVE: begin
                     if (CNT_W'(req_position) >= fill_count_ff) begin
                        rsp_status_in = STATUS_RANGE;
                     end else begin
                        cell_ctl.cmd  = CELL_CLOSE;
                        fill_count_in = fill_count_ff - CNT_W'(1);
                        rsp_count_in  = fill_count_ff - CNT_W'(1);
                     end
                  end
                  OP_DUMP: begin
                     // A non-empty dump streams from the chain head instead.
                     if (fill_count_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        dump_idx_in  = '0;
                        state_in     = ST_DUMP;
                     end
                  end
                  default: begin
                     rsp_status_in = STATUS_OK;
                  end
               endcase
            end
         end
         ST_DUMP: begin
            // Each beat takes the head cell, then the chain turns by one.
            // After fill_count turns every entry is back in its place.
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_element_in       = cell_entry[0];
               rsp_element_valid_in = 1'b1;
               rsp_last_in          = dump_last;
               rsp_status_in        = STATUS_OK;
               rsp_count_in         = fill_count_ff;
               cell_ctl.cmd         = CELL_ROTATE;
               dump_idx_in          = dump_idx_ff + POS_W'(1);
               if (dump_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_count_ff <= fill_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      dump_idx_ff          <= dump_idx_in;
      rsp_element_ff       <= rsp_element_in;
      rsp_element_valid_ff <= rsp_element_valid_in;
      rsp_last_ff          <= rsp_last_in;
      rsp_status_ff        <= rsp_status_in;
      rsp_count_ff         <= rsp_count_in;
   end

   // The cell chain: cell i hands its entry down to cell i - 1.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] next_entry;
      if (i < DEPTH - 1) begin : g_mid
         assign next_entry = cell_entry[i + 1];
      end else begin : g_end
         assign next_entry = '0;
      end

      cas_cell #(
         .IDX   (i),
         .CNT_W (CNT_W),
         .POS_W (POS_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .fill_count (fill_count_ff),
         .position   (req_position),
         .next_entry (next_entry),
         .head_entry (cell_entry[0]),
         .entry      (cell_entry[i])
      );
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_element       = rsp_element_ff;
   assign rsp_element_valid = rsp_element_valid_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_count         = rsp_count_ff;

endmodule
